// ===== rtl/core/sbw_pkg.sv =====
package sbw_pkg;

  // Field widths of one input item and one result item
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned BYTE_W  = 8;

  // Largest legal bit count of a write
  localparam logic [COUNT_W-1:0] MAX_FIELD_BITS = 6'd32;

  // Operation codes carried on the input tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Configuration register indexes (byte address / 4)
  localparam logic REG_LIMIT_ENABLE = 1'b0;
  localparam logic REG_BYTE_LIMIT   = 1'b1;

  // Bit stuffing constants
  localparam logic [BYTE_W-1:0] MARKER_BYTE  = 8'hFF;
  localparam logic [3:0]        FULL_BITS    = 4'd8;
  localparam logic [3:0]        STUFFED_BITS = 4'd7;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_WRITE,
    KIND_FLUSH
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              err;
    logic              last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WRITE,
    BK_FLUSH,
    BK_FLUSH_EXTRA
  } back_state_t;

endpackage

// ===== rtl/core/stuffed_bit_writer_unit.sv =====
// Channel     | Direction | Handshake                    | Contents
// s_axis      | in        | s_axis_tvalid/s_axis_tready  | write or flush command
// m_axis      | out       | m_axis_tvalid/m_axis_tready  | one stuffed byte or an error
// APB         | in/out    | psel/penable, pready = 1     | limit_enable, byte_limit
//
// A write of N bits leaves the command queue in the idle state and then passes through
// the back-end sequencer, one bit placed per cycle while the output does not stall.
// A flush emits the partial byte, then a zero byte in BK_FLUSH_EXTRA if it was 0xFF.
// Writes with a zero or oversized count are accepted and dropped at the front.
// Synchronous active-high reset clears the partial byte, sets eight free bits and zeroes
// the byte counter; no clearing pass. Stalls on m_axis hold the sequencer only when a
// byte is due; the two-entry queue keeps accepting commands meanwhile until it is full.
module stuffed_bit_writer_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] field_value, [37:32] bit_count, [39:38] zero
  input  logic        s_axis_tuser,   // [0] operation
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] overflow_error
  output logic        m_axis_tlast    // last result of the command
);

  logic             limit_enable;
  logic [31:0]      byte_limit;
  logic             cfg_write;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  sbw_pkg::cmd_t    push_cmd;
  sbw_pkg::cmd_t    pop_cmd;
  sbw_pkg::result_t res;

  // Register file: write on the access phase of an APB transfer
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_enable <= 1'b0;
      byte_limit   <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      case (paddr[2])
        sbw_pkg::REG_LIMIT_ENABLE: limit_enable <= pwdata[0];
        sbw_pkg::REG_BYTE_LIMIT:   byte_limit   <= pwdata;
        default:                   limit_enable <= limit_enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sbw_pkg::REG_LIMIT_ENABLE: prdata = {31'd0, limit_enable};
      sbw_pkg::REG_BYTE_LIMIT:   prdata = byte_limit;
      default:                   prdata = '0;
    endcase
  end

  // Front: classify each transfer, drop writes with an empty or oversized count
  sbw_front u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_value (s_axis_tdata[31:0]),
    .in_count (s_axis_tdata[37:32]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Decouple front and back so each side can stall on its own
  sbw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  // Back: bit-serial packer with stuffing, limit check and output register
  sbw_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .limit_enable (limit_enable),
    .byte_limit   (byte_limit),
    .q_empty      (q_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res          (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = res.err;
  assign m_axis_tlast = res.last;

endmodule

// ===== rtl/core/sbw_front.sv =====
module sbw_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [sbw_pkg::VALUE_W-1:0] in_value,
  input  logic [sbw_pkg::COUNT_W-1:0] in_count,
  input  logic                        q_full,
  output logic                        q_push,
  output sbw_pkg::cmd_t               q_cmd
);

  logic keep;

  // Drop writes that move no bit (empty or oversized count)
  always_comb begin
    q_cmd.value = in_value;
    q_cmd.count = in_count;
    if (in_op == sbw_pkg::OP_FLUSH) begin
      q_cmd.kind = sbw_pkg::KIND_FLUSH;
      keep       = 1'b1;
    end else begin
      q_cmd.kind = sbw_pkg::KIND_WRITE;
      keep       = (in_count != '0) && (in_count <= sbw_pkg::MAX_FIELD_BITS);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

// ===== rtl/core/sbw_queue.sv =====
module sbw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sbw_pkg::cmd_t pop_cmd
);

  sbw_pkg::cmd_t                entries [sbw_pkg::QDEPTH];
  logic [sbw_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sbw_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sbw_pkg::QCNT_W-1:0]   fill;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (fill == sbw_pkg::QCNT_W'(sbw_pkg::QDEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == sbw_pkg::QPTR_W'(sbw_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == sbw_pkg::QPTR_W'(sbw_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbw_back.sv =====
module sbw_back #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  limit_enable,
  input  logic [31:0]           byte_limit,
  input  logic                  q_empty,
  input  sbw_pkg::cmd_t         q_cmd,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output sbw_pkg::result_t      res
);

  localparam int unsigned CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  sbw_pkg::back_state_t              state;
  sbw_pkg::back_state_t              state_next;
  logic [sbw_pkg::BYTE_W-1:0]        partial_byte;
  logic [sbw_pkg::BYTE_W-1:0]        partial_byte_next;
  logic [3:0]                        bits_free;
  logic [3:0]                        bits_free_next;
  logic [COUNT_BITS-1:0]             bytes_emitted;
  logic [COUNT_BITS-1:0]             bytes_emitted_next;
  logic [sbw_pkg::VALUE_W-1:0]       value;
  logic [sbw_pkg::VALUE_W-1:0]       value_next;
  logic [sbw_pkg::COUNT_W-1:0]       remaining;
  logic [sbw_pkg::COUNT_W-1:0]       remaining_next;
  logic                              res_valid_next;
  sbw_pkg::result_t                  res_next;

  logic [CMP_W-1:0]                  count_ext;
  logic [CMP_W-1:0]                  limit_ext;
  logic                              limit_hit;
  logic                              need_emit;
  logic                              out_free;
  logic                              stall;
  logic                              cur_bit;
  logic [$clog2(sbw_pkg::VALUE_W)-1:0] bit_idx;
  logic [3:0]                        emit_free;

  assign count_ext = CMP_W'(bytes_emitted);
  assign limit_ext = CMP_W'(byte_limit);
  assign limit_hit = limit_enable && (count_ext >= limit_ext);
  assign need_emit = ((state == sbw_pkg::BK_WRITE) && (bits_free == '0)) ||
                     (state == sbw_pkg::BK_FLUSH) || (state == sbw_pkg::BK_FLUSH_EXTRA);
  assign out_free  = !res_valid || res_ready;
  assign stall     = need_emit && !out_free;
  assign bit_idx   = ($clog2(sbw_pkg::VALUE_W))'(remaining - 1'b1);
  assign cur_bit   = value[bit_idx];
  assign emit_free = (partial_byte == sbw_pkg::MARKER_BYTE) ? sbw_pkg::STUFFED_BITS
                                                            : sbw_pkg::FULL_BITS;

  always_comb begin
    state_next = state;
    case (state)
      sbw_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = (q_cmd.kind == sbw_pkg::KIND_FLUSH) ? sbw_pkg::BK_FLUSH
                                                           : sbw_pkg::BK_WRITE;
        end
      end
      sbw_pkg::BK_WRITE: begin
        if (!stall) begin
          if ((need_emit && limit_hit) || (remaining == sbw_pkg::COUNT_W'(1))) begin
            state_next = sbw_pkg::BK_IDLE;
          end
        end
      end
      sbw_pkg::BK_FLUSH: begin
        if (!stall) begin
          if (!limit_hit && (partial_byte == sbw_pkg::MARKER_BYTE)) begin
            state_next = sbw_pkg::BK_FLUSH_EXTRA;
          end else begin
            state_next = sbw_pkg::BK_IDLE;
          end
        end
      end
      sbw_pkg::BK_FLUSH_EXTRA: begin
        if (!stall) begin
          state_next = sbw_pkg::BK_IDLE;
        end
      end
      default: state_next = sbw_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop              = 1'b0;
    partial_byte_next  = partial_byte;
    bits_free_next     = bits_free;
    bytes_emitted_next = bytes_emitted;
    value_next         = value;
    remaining_next     = remaining;
    res_valid_next     = res_valid && !res_ready;
    res_next           = res;
    case (state)
      sbw_pkg::BK_IDLE: begin
        q_pop          = !q_empty;
        value_next     = q_cmd.value;
        remaining_next = q_cmd.count;
      end
      sbw_pkg::BK_WRITE: begin
        if (!stall) begin
          if (need_emit) begin
            res_valid_next = 1'b1;
            if (limit_hit) begin
              res_next.data = '0;
              res_next.err  = 1'b1;
              res_next.last = 1'b1;
            end else begin
              res_next.data = partial_byte;
              res_next.err  = 1'b0;
              res_next.last = (remaining <= sbw_pkg::COUNT_W'(emit_free));
              if (limit_enable) begin
                bytes_emitted_next = bytes_emitted + 1'b1;
              end
              partial_byte_next = sbw_pkg::BYTE_W'(cur_bit) << 3'(emit_free - 1'b1);
              bits_free_next    = emit_free - 1'b1;
              remaining_next    = remaining - 1'b1;
            end
          end else begin
            partial_byte_next = partial_byte |
                                (sbw_pkg::BYTE_W'(cur_bit) << 3'(bits_free - 1'b1));
            bits_free_next    = bits_free - 1'b1;
            remaining_next    = remaining - 1'b1;
          end
        end
      end
      sbw_pkg::BK_FLUSH, sbw_pkg::BK_FLUSH_EXTRA: begin
        if (!stall) begin
          res_valid_next = 1'b1;
          if (limit_hit) begin
            res_next.data = '0;
            res_next.err  = 1'b1;
            res_next.last = 1'b1;
          end else begin
            res_next.data = partial_byte;
            res_next.err  = 1'b0;
            res_next.last = (state == sbw_pkg::BK_FLUSH_EXTRA) ||
                            (partial_byte != sbw_pkg::MARKER_BYTE);
            if (limit_enable) begin
              bytes_emitted_next = bytes_emitted + 1'b1;
            end
            partial_byte_next = '0;
            bits_free_next    = emit_free;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sbw_pkg::BK_IDLE;
      partial_byte  <= '0;
      bits_free     <= sbw_pkg::FULL_BITS;
      bytes_emitted <= '0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      partial_byte  <= partial_byte_next;
      bits_free     <= bits_free_next;
      bytes_emitted <= bytes_emitted_next;
      res_valid     <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value     <= value_next;
    remaining <= remaining_next;
    res       <= res_next;
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.err |-> res.last)
    else $error("error result not marked last");

  a_err_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.err |-> (res.data == '0))
    else $error("error result carries a nonzero byte");

  a_bits_free_range: assert property (@(posedge clk) disable iff (rst)
    bits_free <= sbw_pkg::FULL_BITS)
    else $error("free bit count out of range");

  a_no_count_unlimited: assert property (@(posedge clk) disable iff (rst)
    !limit_enable |=> $stable(bytes_emitted))
    else $error("byte counter moved in unlimited mode");

endmodule
